[rtl/core/lrmd_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the reflector marker detector.
// Depends on nothing; every other file of the block but lrmd_ram imports it.
package lrmd_pkg;

  localparam int RNG_W      = 16;
  localparam int INT_W      = 16;
  localparam int OFF_W      = 11;
  localparam int TRIG_W     = 15;
  localparam int PT_W       = 18;
  localparam int NUM_W      = 5;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ANG_W      = 10;
  localparam int HALF_W     = 8;
  localparam int QTR_N      = 181;
  localparam int PROD_W     = RNG_W + TRIG_W;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  localparam logic [KIND_W-1:0] KIND_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTENSITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_OFFSET  = 2'd1;

  localparam logic [INT_W-1:0] MIN_INT_RESET = 16'd0;
  localparam logic [OFF_W-1:0] OFF_RESET     = 11'd300;

  // Folded angle: index into the quarter-wave table plus the sign of the result.
  typedef struct packed {
    logic [HALF_W-1:0] h;
    logic              neg;
  } fold_t;

  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
  } point_t;

  // Records one input causes, in output order front, rear, end.
  typedef struct packed {
    logic             fm;
    logic             rm;
    logic             em;
    logic [NUM_W-1:0] f_num;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] total;
    logic             ovf;
  } rec_ctl_t;

  // Per-stage load enables of the lane pipelines and the store write strobe.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic wr;
  } pipe_ctl_t;

  typedef logic [QTR_N-1:0][TRIG_W-1:0] sin_tab_t;

  // Sine of h half-degrees (0..180) as a Q15 magnitude; truncated Q30 Taylor series.
  function automatic logic [TRIG_W-1:0] quarter_sin(input logic [HALF_W-1:0] h);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] q;
    begin
      x    = (64'(h) * PI_Q30) / 64'd360;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      term = ((term * x2) >> 30) / 64'd6;
      neg  = term;
      term = ((term * x2) >> 30) / 64'd20;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 64'd42;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 64'd72;
      pos  = pos + term;
      term = ((term * x2) >> 30) / 64'd110;
      neg  = neg + term;
      term = ((term * x2) >> 30) / 64'd156;
      pos  = pos + term;
      s    = (pos > neg) ? (pos - neg) : 64'd0;
      q    = (s + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      return q[TRIG_W-1:0];
    end
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    begin
      for (int h = 0; h < QTR_N; h++) begin
        t[h] = quarter_sin(HALF_W'(h));
      end
      return t;
    end
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // Maps a half-degree angle 0..719 onto the quarter wave.
  function automatic fold_t fold_angle(input logic [ANG_W-1:0] a);
    fold_t r;
    begin
      r.neg = 1'b0;
      r.h   = a[HALF_W-1:0];
      if (a <= ANG_W'(180)) begin
        r.h = a[HALF_W-1:0];
      end else if (a <= ANG_W'(360)) begin
        r.h = HALF_W'(ANG_W'(360) - a);
      end else if (a <= ANG_W'(540)) begin
        r.h   = HALF_W'(a - ANG_W'(360));
        r.neg = 1'b1;
      end else begin
        r.h   = HALF_W'(ANG_W'(720) - a);
        r.neg = 1'b1;
      end
      return r;
    end
  endfunction

endpackage

[rtl/core/lrmd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module lrmd_ram #(
  parameter int W     = 36,
  parameter int DEPTH = 541
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/lrmd_lane.sv]
// One scanner lane: trig lookup, range multiply, rounding, point store and marker read.
// Depends on lrmd_pkg and lrmd_ram.
module lrmd_lane #(
  parameter int BEAMS = 541
) (
  input  logic                        clk,
  input  lrmd_pkg::pipe_ctl_t         ctl,
  input  logic [lrmd_pkg::RNG_W-1:0]  rng,
  input  lrmd_pkg::fold_t             fs,
  input  lrmd_pkg::fold_t             fc,
  input  logic [$clog2(BEAMS)-1:0]    idx,
  input  logic [$clog2(BEAMS)-1:0]    mid,
  input  logic [lrmd_pkg::OFF_W-1:0]  off,
  output lrmd_pkg::point_t            pt
);
  import lrmd_pkg::*;

  localparam int IW = $clog2(BEAMS);

  logic [RNG_W-1:0]  rng1_r, rng2_r;
  fold_t             fs1_r, fc1_r;
  logic              ns2_r, nc2_r, ns3_r, nc3_r;
  logic [TRIG_W-1:0] ms2_r, mc2_r;
  logic [PROD_W-1:0] ps3_r, pc3_r;
  logic [IW-1:0]     idx1_r, idx2_r, idx3_r, idx4_r;
  logic [IW-1:0]     mid1_r, mid2_r, mid3_r, mid4_r;
  logic              fwd4_r, fwd5_r;
  point_t            pt4_r, pt5_r, pt_nxt;
  logic [PROD_W:0]   rc_sum, rs_sum;
  logic [PT_W-1:0]   mc_u, ms_u;
  logic signed [PT_W-1:0] vc, vs;
  logic [2*PT_W-1:0] rd_data;

  // Round half away from zero: round the magnitude, then apply the sign.
  always_comb begin
    rc_sum   = {1'b0, pc3_r} + ((PROD_W+1)'(1) << (TRIG_W - 1));
    rs_sum   = {1'b0, ps3_r} + ((PROD_W+1)'(1) << (TRIG_W - 1));
    mc_u     = PT_W'(rc_sum[PROD_W:TRIG_W]);
    ms_u     = PT_W'(rs_sum[PROD_W:TRIG_W]);
    vc       = nc3_r ? -$signed(mc_u) : $signed(mc_u);
    vs       = ns3_r ? -$signed(ms_u) : $signed(ms_u);
    pt_nxt.x = vc + $signed(PT_W'(off));
    pt_nxt.y = vs;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      rng1_r <= rng;
      fs1_r  <= fs;
      fc1_r  <= fc;
      idx1_r <= idx;
      mid1_r <= mid;
    end
    if (ctl.ld2) begin
      rng2_r <= rng1_r;
      ms2_r  <= SIN_TAB[fs1_r.h];
      mc2_r  <= SIN_TAB[fc1_r.h];
      ns2_r  <= fs1_r.neg;
      nc2_r  <= fc1_r.neg;
      idx2_r <= idx1_r;
      mid2_r <= mid1_r;
    end
    if (ctl.ld3) begin
      ps3_r  <= PROD_W'(rng2_r) * PROD_W'(ms2_r);
      pc3_r  <= PROD_W'(rng2_r) * PROD_W'(mc2_r);
      ns3_r  <= ns2_r;
      nc3_r  <= nc2_r;
      idx3_r <= idx2_r;
      mid3_r <= mid2_r;
    end
    if (ctl.ld4) begin
      pt4_r  <= pt_nxt;
      idx4_r <= idx3_r;
      mid4_r <= mid3_r;
      fwd4_r <= (mid3_r == idx3_r);
    end
    if (ctl.ld5) begin
      pt5_r  <= pt4_r;
      fwd5_r <= fwd4_r;
    end
  end

  lrmd_ram #(
    .W     (2 * PT_W),
    .DEPTH (BEAMS)
  ) u_store (
    .clk   (clk),
    .we    (ctl.wr),
    .waddr (idx4_r),
    .wdata (pt4_r),
    .re    (ctl.ld5),
    .raddr (mid4_r),
    .rdata (rd_data)
  );

  // The store returns old data when the marker sits on this item's own beam slot.
  assign pt = fwd5_r ? pt5_r : point_t'(rd_data);

endmodule

[rtl/core/lrmd_merge.sv]
// Output stage: holds one item's records and hands them out front, rear, end.
// Depends on lrmd_pkg.
module lrmd_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld,
  input  lrmd_pkg::rec_ctl_t          ctl,
  input  lrmd_pkg::point_t            fpt,
  input  lrmd_pkg::point_t            rpt,
  output logic                        free,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lrmd_pkg::KIND_W-1:0] out_record_kind,
  output logic signed [lrmd_pkg::PT_W-1:0] out_x_mm,
  output logic signed [lrmd_pkg::PT_W-1:0] out_y_mm,
  output logic [lrmd_pkg::NUM_W-1:0]  out_marker_number,
  output logic [lrmd_pkg::NUM_W-1:0]  out_marker_total,
  output logic                        out_overflow,
  output logic                        out_last
);
  import lrmd_pkg::*;

  logic [2:0] pend_r, pend_nxt;
  rec_ctl_t   ctl_r;
  logic       single;

  assign out_valid = |pend_r;
  assign single    = ((pend_r & (pend_r - 3'd1)) == 3'd0);
  assign free      = !out_valid || (out_ready && single);
  assign out_last  = single;

  always_comb begin
    pend_nxt = pend_r;
    if (free) begin
      pend_nxt = vld ? {ctl.em, ctl.rm, ctl.fm} : 3'd0;
    end else if (out_ready) begin
      pend_nxt = pend_r & (pend_r - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      ctl_r <= ctl;
    end
  end

  // The rear lane stores points in front form; the rear mount mirrors them.
  always_comb begin
    out_record_kind   = KIND_END;
    out_x_mm          = '0;
    out_y_mm          = '0;
    out_marker_number = '0;
    out_marker_total  = ctl_r.total;
    out_overflow      = ctl_r.ovf;
    if (pend_r[0]) begin
      out_record_kind   = KIND_FRONT;
      out_x_mm          = fpt.x;
      out_y_mm          = fpt.y;
      out_marker_number = ctl_r.f_num;
      out_marker_total  = '0;
      out_overflow      = 1'b0;
    end else if (pend_r[1]) begin
      out_record_kind   = KIND_REAR;
      out_x_mm          = -rpt.x;
      out_y_mm          = -rpt.y;
      out_marker_number = ctl_r.r_num;
      out_marker_total  = '0;
      out_overflow      = 1'b0;
    end
  end

endmodule

[rtl/core/lidar_reflector_marker_detect.sv]
// Top level of the reflector marker detector: request control, run detection and pipeline.
// Depends on lrmd_pkg, lrmd_lane (with lrmd_ram) and lrmd_merge.
//
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid / in_ready  | front/rear range and intensity, last_beam
// out     | out | out_valid / out_ready| record_kind, x_mm, y_mm, marker_number, total, ...
// cfg     | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request is accepted every cycle while each one causes at most one record and the output
// is not stalled; a request that causes several records holds the output stage until all
// of them are taken. A request passes through angle fold, sine table, multiply, round and
// store, and store read, each registered, before its first record leaves.
// Reset is synchronous and active low. The point stores are never cleared; a marker only
// reads beam slots written earlier in the same scan.
// A stalled output holds only the output stage; earlier stages keep filling until full.
module lidar_reflector_marker_detect #(
  parameter int BEAMS       = 541,
  parameter int MAX_MARKERS = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [lrmd_pkg::RNG_W-1:0]       in_front_range,
  input  logic [lrmd_pkg::INT_W-1:0]       in_front_intensity,
  input  logic [lrmd_pkg::RNG_W-1:0]       in_rear_range,
  input  logic [lrmd_pkg::INT_W-1:0]       in_rear_intensity,
  input  logic                             in_last_beam,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lrmd_pkg::KIND_W-1:0]      out_record_kind,
  output logic signed [lrmd_pkg::PT_W-1:0] out_x_mm,
  output logic signed [lrmd_pkg::PT_W-1:0] out_y_mm,
  output logic [lrmd_pkg::NUM_W-1:0]       out_marker_number,
  output logic [lrmd_pkg::NUM_W-1:0]       out_marker_total,
  output logic                             out_overflow,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lrmd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lrmd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lrmd_pkg::*;

  localparam int IW = $clog2(BEAMS);
  localparam int MW = $clog2(MAX_MARKERS + 1);

  // Configuration registers.
  logic [INT_W-1:0] min_int_r;
  logic [OFF_W-1:0] off_r;

  // Per-scan state.
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          f_run_r, f_run_nxt, r_run_r, r_run_nxt;
  logic [IW-1:0] f_start_r, f_start_nxt, r_start_r, r_start_nxt;
  logic [MW-1:0] mf_r, mf_nxt;
  logic          drop_r, drop_nxt;

  // Pipeline valid bits and record control riding along with the lanes.
  logic      v1_r, v2_r, v3_r, v4_r;
  rec_ctl_t  c1_r, c2_r, c3_r, c4_r, c_nxt;
  pipe_ctl_t pctl;
  logic      merge_free;
  logic      in_acc;

  // Angle and run detection for the request at the input.
  logic [ANG_W:0]   a_sum, c_sum;
  logic [ANG_W-1:0] a_sin, a_cos;
  fold_t            fs, fc;
  logic             f_open, f_close, r_open, r_close;
  logic             f_keep, r_keep;
  logic [IW-1:0]    f_mid, r_mid;
  logic [MW-1:0]    mf_a, mf_b;
  logic             drop_b;
  point_t           fpt, rpt;

  // Stall chain: a stage loads when it is empty or its contents move on.
  always_comb begin
    pctl.ld5 = merge_free;
    pctl.ld4 = !v4_r || pctl.ld5;
    pctl.ld3 = !v3_r || pctl.ld4;
    pctl.ld2 = !v2_r || pctl.ld3;
    pctl.ld1 = !v1_r || pctl.ld2;
    pctl.wr  = v4_r && pctl.ld5;
  end

  assign in_ready  = pctl.ld1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Beam i sits at -135 + 0.5*i degrees, i.e. (i + 450) mod 720 half-degrees;
  // cosine is the same table a quarter turn later.
  always_comb begin
    a_sum = (ANG_W+1)'(cnt_r) + (ANG_W+1)'(450);
    if (a_sum >= (ANG_W+1)'(1440)) begin
      a_sin = ANG_W'(a_sum - (ANG_W+1)'(1440));
    end else if (a_sum >= (ANG_W+1)'(720)) begin
      a_sin = ANG_W'(a_sum - (ANG_W+1)'(720));
    end else begin
      a_sin = ANG_W'(a_sum);
    end
    c_sum = (ANG_W+1)'(a_sin) + (ANG_W+1)'(180);
    if (c_sum >= (ANG_W+1)'(720)) begin
      a_cos = ANG_W'(c_sum - (ANG_W+1)'(720));
    end else begin
      a_cos = ANG_W'(c_sum);
    end
    fs = fold_angle(a_sin);
    fc = fold_angle(a_cos);
  end

  // A run opens above the threshold and closes below it; equal leaves it alone.
  // The front scanner claims a marker slot before the rear one.
  always_comb begin
    f_open  = (in_front_intensity > min_int_r) && !f_run_r;
    f_close = (in_front_intensity < min_int_r) && f_run_r;
    r_open  = (in_rear_intensity > min_int_r) && !r_run_r;
    r_close = (in_rear_intensity < min_int_r) && r_run_r;
    f_mid   = f_start_r + ((cnt_r - f_start_r) >> 1);
    r_mid   = r_start_r + ((cnt_r - r_start_r) >> 1);
    f_keep  = f_close && (mf_r < MW'(MAX_MARKERS));
    mf_a    = f_keep ? mf_r + 1'b1 : mf_r;
    r_keep  = r_close && (mf_a < MW'(MAX_MARKERS));
    mf_b    = r_keep ? mf_a + 1'b1 : mf_a;
    drop_b  = drop_r || (f_close && !f_keep) || (r_close && !r_keep);

    c_nxt.fm    = f_keep;
    c_nxt.rm    = r_keep;
    c_nxt.em    = in_last_beam;
    c_nxt.f_num = NUM_W'(mf_r);
    c_nxt.r_num = NUM_W'(mf_a);
    c_nxt.total = NUM_W'(mf_b);
    c_nxt.ovf   = drop_b;
  end

  // Scan state advances with each accepted request and clears after the last beam.
  // The beam counter sticks at the final slot if a scan runs long.
  always_comb begin
    cnt_nxt     = cnt_r;
    f_run_nxt   = f_run_r;
    r_run_nxt   = r_run_r;
    f_start_nxt = f_start_r;
    r_start_nxt = r_start_r;
    mf_nxt      = mf_r;
    drop_nxt    = drop_r;
    if (in_acc) begin
      if (in_last_beam) begin
        cnt_nxt     = '0;
        f_run_nxt   = 1'b0;
        r_run_nxt   = 1'b0;
        f_start_nxt = '0;
        r_start_nxt = '0;
        mf_nxt      = '0;
        drop_nxt    = 1'b0;
      end else begin
        if (cnt_r != IW'(BEAMS - 1)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (f_open) begin
          f_run_nxt   = 1'b1;
          f_start_nxt = cnt_r;
        end else if (f_close) begin
          f_run_nxt = 1'b0;
        end
        if (r_open) begin
          r_run_nxt   = 1'b1;
          r_start_nxt = cnt_r;
        end else if (r_close) begin
          r_run_nxt = 1'b0;
        end
        mf_nxt   = mf_b;
        drop_nxt = drop_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_int_r <= MIN_INT_RESET;
      off_r     <= OFF_RESET;
      cnt_r     <= '0;
      f_run_r   <= 1'b0;
      r_run_r   <= 1'b0;
      f_start_r <= '0;
      r_start_r <= '0;
      mf_r      <= '0;
      drop_r    <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MIN_INTENSITY: min_int_r <= cfg_data[INT_W-1:0];
          REG_MOUNT_OFFSET:  off_r     <= cfg_data[OFF_W-1:0];
          default: ;
        endcase
      end
      cnt_r     <= cnt_nxt;
      f_run_r   <= f_run_nxt;
      r_run_r   <= r_run_nxt;
      f_start_r <= f_start_nxt;
      r_start_r <= r_start_nxt;
      mf_r      <= mf_nxt;
      drop_r    <= drop_nxt;
      if (pctl.ld1) v1_r <= in_valid;
      if (pctl.ld2) v2_r <= v1_r;
      if (pctl.ld3) v3_r <= v2_r;
      if (pctl.ld4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pctl.ld1) c1_r <= c_nxt;
    if (pctl.ld2) c2_r <= c1_r;
    if (pctl.ld3) c3_r <= c2_r;
    if (pctl.ld4) c4_r <= c3_r;
  end

  // Both lanes compute the front-mount form r*(cos, sin) + (offset, 0);
  // the output stage mirrors rear points.
  lrmd_lane #(
    .BEAMS (BEAMS)
  ) u_front (
    .clk (clk),
    .ctl (pctl),
    .rng (in_front_range),
    .fs  (fs),
    .fc  (fc),
    .idx (cnt_r),
    .mid (f_mid),
    .off (off_r),
    .pt  (fpt)
  );

  lrmd_lane #(
    .BEAMS (BEAMS)
  ) u_rear (
    .clk (clk),
    .ctl (pctl),
    .rng (in_rear_range),
    .fs  (fs),
    .fc  (fc),
    .idx (cnt_r),
    .mid (r_mid),
    .off (off_r),
    .pt  (rpt)
  );

  lrmd_merge u_merge (
    .clk               (clk),
    .rst_n             (rst_n),
    .vld               (v4_r),
    .ctl               (c4_r),
    .fpt               (fpt),
    .rpt               (rpt),
    .free              (merge_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_kind   (out_record_kind),
    .out_x_mm          (out_x_mm),
    .out_y_mm          (out_y_mm),
    .out_marker_number (out_marker_number),
    .out_marker_total  (out_marker_total),
    .out_overflow      (out_overflow),
    .out_last          (out_last)
  );

  // An empty output stage must never hold off new requests.
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while the output stage is empty");

  // The kept-marker count never passes the cap.
  a_marker_cap: assert property (@(posedge clk) disable iff (!rst_n)
    mf_r <= MW'(MAX_MARKERS))
    else $error("marker count above cap");

  // The beam counter saturates at the last slot.
  a_beam_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= IW'(BEAMS - 1))
    else $error("beam counter beyond last slot");

  // Marker records carry no total and no drop flag.
  a_marker_rec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_record_kind != KIND_END)) |->
      (!out_overflow && (out_marker_total == '0)))
    else $error("marker record with total or overflow set");

endmodule

[tb/lidar_reflector_marker_detect_test.sv]
// Self-checking testbench for the lidar reflector marker detector: directed rows, then random scans.
// Depends on lrmd_pkg and the lidar_reflector_marker_detect RTL; needs no other file.
`timescale 1ns / 100ps

module lidar_reflector_marker_detect_test;
  import lrmd_pkg::*;

  localparam int BEAMS        = 541;
  localparam int MAX_MARKERS  = 20;
  localparam int OFF_MAX      = 2000;
  // Margin that drain waits out after the last expected record, for requests with no record.
  localparam int SETTLE       = 12;
  localparam int LONG_STALL   = 300;
  localparam int RAND_ITEMS   = 330;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DIR_ROWS     = 18;

  // How a request's records are predicted: by the predictor, or typed straight into the table.
  typedef enum logic [1:0] {BY_MODEL, NO_RECORD, END_ONLY} check_e;
  typedef enum logic [1:0] {ROW_BEAM, ROW_CFG} row_op_e;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic [NUM_W-1:0]       num;
    logic [NUM_W-1:0]       total;
    logic                   ovf;
    logic                   last;
  } marker_rec_t;

  typedef struct packed {
    check_e           chk;
    logic [NUM_W-1:0] total;
  } beam_check_t;

  typedef struct packed {
    row_op_e                 op;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    logic [RNG_W-1:0]        f_rng;
    logic [INT_W-1:0]        f_int;
    logic [RNG_W-1:0]        r_rng;
    logic [INT_W-1:0]        r_int;
    logic                    lb;
    check_e                  chk;
    logic [NUM_W-1:0]        total;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [RNG_W-1:0]       in_front_range;
  logic [INT_W-1:0]       in_front_intensity;
  logic [RNG_W-1:0]       in_rear_range;
  logic [INT_W-1:0]       in_rear_intensity;
  logic                   in_last_beam;
  logic                   out_valid;
  logic                   out_ready;
  logic [KIND_W-1:0]      out_record_kind;
  logic signed [PT_W-1:0] out_x_mm;
  logic signed [PT_W-1:0] out_y_mm;
  logic [NUM_W-1:0]       out_marker_number;
  logic [NUM_W-1:0]       out_marker_total;
  logic                   out_overflow;
  logic                   out_last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shared controls between the request driver and the result sink.
  bit gaps_on = 1'b1;
  bit long_stall_req = 1'b0;
  bit pause_req = 1'b0;

  int unsigned cycle_count = 0;
  int          mismatches = 0;

  marker_rec_t pending_records[$];
  beam_check_t beam_checks[$];

  // Predictor copy of the block's registers and per-scan state.
  int          min_level = int'(MIN_INT_RESET);
  int          mount_off = int'(OFF_RESET);
  int          beam_idx = 0;
  bit          in_run [2] = '{1'b0, 1'b0};
  int          run_start [2] = '{0, 0};
  int          found = 0;
  bit          dropped = 1'b0;
  int          pt_x [2][BEAMS];
  int          pt_y [2][BEAMS];
  marker_rec_t new_recs [3];
  int          new_count;

  // Directed rows. Configuration rows are written only once the block has gone quiet.
  stim_row_t dir_rows [DIR_ROWS] = '{
    // A lone last beam right after reset closes an empty scan.
    '{ROW_BEAM, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, END_ONLY, 5'd0},
    // Full-scale ranges and intensities open both runs at the reset threshold.
    '{ROW_BEAM, 2'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_RECORD, 5'd0},
    // Runs still open on the last beam are dropped without a marker.
    '{ROW_BEAM, 2'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, END_ONLY, 5'd0},
    '{ROW_CFG, REG_MIN_INTENSITY, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, BY_MODEL, 5'd0},
    '{ROW_CFG, REG_MOUNT_OFFSET, 16'd2000, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, BY_MODEL, 5'd0},
    '{ROW_BEAM, 2'd0, 16'd0, 16'hFFFF, 16'd2000, 16'hFFFF, 16'd2000, 1'b0, NO_RECORD, 5'd0},
    // Intensity equal to the threshold leaves both runs as they are.
    '{ROW_BEAM, 2'd0, 16'd0, 16'd1234, 16'd1000, 16'd4321, 16'd1000, 1'b0, NO_RECORD, 5'd0},
    // Both runs close on the same beam: front marker first, then rear.
    '{ROW_BEAM, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd999, 1'b0, BY_MODEL, 5'd0},
    '{ROW_BEAM, 2'd0, 16'd0, 16'd40000, 16'd1001, 16'd0, 16'd0, 1'b0, NO_RECORD, 5'd0},
    '{ROW_BEAM, 2'd0, 16'd0, 16'd0, 16'd999, 16'hFFFF, 16'hFFFF, 1'b0, BY_MODEL, 5'd0},
    // A marker and the end record come from one request.
    '{ROW_BEAM, 2'd0, 16'd0, 16'd777, 16'd1000, 16'd1, 16'd0, 1'b1, BY_MODEL, 5'd0},
    '{ROW_CFG, REG_MOUNT_OFFSET, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, BY_MODEL, 5'd0},
    '{ROW_CFG, REG_MIN_INTENSITY, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, BY_MODEL, 5'd0},
    // Nothing can exceed the top threshold, so no run opens.
    '{ROW_BEAM, 2'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, NO_RECORD, 5'd0},
    '{ROW_BEAM, 2'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, END_ONLY, 5'd0},
    '{ROW_CFG, REG_MIN_INTENSITY, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0, BY_MODEL, 5'd0},
    '{ROW_BEAM, 2'd0, 16'd0, 16'd9, 16'd1, 16'd9, 16'd1, 1'b0, NO_RECORD, 5'd0},
    // With a zero threshold a run can never close.
    '{ROW_BEAM, 2'd0, 16'd0, 16'd9, 16'd0, 16'd9, 16'd0, 1'b1, END_ONLY, 5'd0}
  };

  lidar_reflector_marker_detect #(
    .BEAMS      (BEAMS),
    .MAX_MARKERS(MAX_MARKERS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_front_range    (in_front_range),
    .in_front_intensity(in_front_intensity),
    .in_rear_range     (in_rear_range),
    .in_rear_intensity (in_rear_intensity),
    .in_last_beam      (in_last_beam),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_record_kind   (out_record_kind),
    .out_x_mm          (out_x_mm),
    .out_y_mm          (out_y_mm),
    .out_marker_number (out_marker_number),
    .out_marker_total  (out_marker_total),
    .out_overflow      (out_overflow),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sine of a half-degree angle as a signed Q15 value. The quarter wave is a Q30 Taylor
  // series through the x^13 term with each term truncated, then rounded half up to Q15.
  function automatic int half_deg_sine(input int a);
    int                h;
    int                k;
    bit                neg;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   plus;
    longint unsigned   minus;
    longint unsigned   q;
    a = a % 720;
    neg = (a > 360);
    if (a <= 180) begin
      h = a;
    end else if (a <= 360) begin
      h = 360 - a;
    end else if (a <= 540) begin
      h = a - 360;
    end else begin
      h = 720 - a;
    end
    x = 64'(h) * PI_Q30 / 64'd360;
    x2 = (x * x) >> 30;
    term = x;
    plus = x;
    minus = 0;
    for (k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        minus += term;
      end else begin
        plus += term;
      end
    end
    q = (plus > minus) ? plus - minus : 0;
    q = (q + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return neg ? -int'(q) : int'(q);
  endfunction

  // Range times a Q15 factor, rounded half away from zero to whole millimetres.
  function automatic int q15_scale(input int r, input int t);
    longint unsigned m;
    int              v;
    m = 64'(r) * 64'((t < 0) ? -t : t);
    v = int'((m + 64'd16384) >> 15);
    return (t < 0) ? -v : v;
  endfunction

  // Stores the beam's points, runs the front and rear reflector runs and fills new_recs
  // with the marker and end-of-scan records that this beam produces.
  task automatic beam_to_records(input logic [RNG_W-1:0] fr, input logic [INT_W-1:0] fi,
                                 input logic [RNG_W-1:0] rr, input logic [INT_W-1:0] ri,
                                 input logic lb);
    int slot;
    int a;
    int s;
    int c;
    int k;
    int mid;
    int inten [2];
    new_count = 0;
    slot = (beam_idx >= BEAMS) ? BEAMS - 1 : beam_idx;
    a = (slot + 450) % 720;
    s = half_deg_sine(a);
    c = half_deg_sine(a + 180);
    pt_x[0][slot] = q15_scale(int'(fr), c) + mount_off;
    pt_y[0][slot] = q15_scale(int'(fr), s);
    pt_x[1][slot] = -q15_scale(int'(rr), c) - mount_off;
    pt_y[1][slot] = -q15_scale(int'(rr), s);
    inten[0] = int'(fi);
    inten[1] = int'(ri);
    for (k = 0; k < 2; k++) begin
      if (inten[k] > min_level && !in_run[k]) begin
        run_start[k] = slot;
        in_run[k] = 1'b1;
      end else if (inten[k] < min_level && in_run[k]) begin
        in_run[k] = 1'b0;
        mid = run_start[k] + (slot - run_start[k]) / 2;
        if (mid >= BEAMS) begin
          mid = BEAMS - 1;
        end
        if (found < MAX_MARKERS) begin
          new_recs[new_count] = '{kind: (k == 0) ? KIND_FRONT : KIND_REAR,
                                  x: PT_W'(pt_x[k][mid]), y: PT_W'(pt_y[k][mid]),
                                  num: NUM_W'(found), total: '0, ovf: dropped, last: 1'b0};
          found++;
          new_count++;
        end else begin
          dropped = 1'b1;
        end
      end
    end
    if (lb) begin
      new_recs[new_count] = '{kind: KIND_END, x: '0, y: '0, num: '0,
                              total: NUM_W'(found), ovf: dropped, last: 1'b0};
      new_count++;
      beam_idx = 0;
      in_run[0] = 1'b0;
      in_run[1] = 1'b0;
      run_start[0] = 0;
      run_start[1] = 0;
      found = 0;
      dropped = 1'b0;
    end else if (slot + 1 < BEAMS) begin
      beam_idx = slot + 1;
    end else begin
      beam_idx = BEAMS - 1;
    end
    if (new_count > 0) begin
      new_recs[new_count - 1].last = 1'b1;
    end
  endtask

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // All handshakes are sampled here at the rising edge, before any input driven at the same
  // edge takes effect. Results are checked first, then configuration, then new requests.
  always @(posedge clk) begin : watch
    marker_rec_t want;
    beam_check_t bc;
    int          j;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_records.size() == 0) begin
          mismatches++;
          $display("%0t: record with none expected, expected none actual kind %0d",
                   $time, out_record_kind);
        end else begin
          want = pending_records.pop_front();
          check_field("record_kind", want.kind, out_record_kind);
          check_field("x_mm", $signed(want.x), $signed(out_x_mm));
          check_field("y_mm", $signed(want.y), $signed(out_y_mm));
          check_field("marker_number", want.num, out_marker_number);
          check_field("marker_total", want.total, out_marker_total);
          check_field("overflow", want.ovf, out_overflow);
          check_field("last", want.last, out_last);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MIN_INTENSITY) begin
          min_level = int'(cfg_data);
        end else if (cfg_index == REG_MOUNT_OFFSET) begin
          mount_off = int'(cfg_data[OFF_W-1:0]);
        end
      end
      if (in_valid && in_ready) begin
        if (beam_checks.size() != 0) begin
          bc = beam_checks.pop_front();
        end else begin
          bc.chk   = BY_MODEL;
          bc.total = '0;
        end
        // The predictor always runs so that its state keeps step with the block.
        beam_to_records(in_front_range, in_front_intensity, in_rear_range,
                        in_rear_intensity, in_last_beam);
        if (bc.chk == BY_MODEL) begin
          for (j = 0; j < new_count; j++) begin
            pending_records.push_back(new_recs[j]);
          end
        end else if (bc.chk == END_ONLY) begin
          pending_records.push_back('{kind: KIND_END, x: '0, y: '0, num: '0,
                                      total: bc.total, ovf: 1'b0, last: 1'b1});
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lidar_reflector_marker_detect verification failed");
      $finish;
    end
  end

  // Result sink. It stalls in random bursts, and once holds off for a long stretch so that
  // the block fills and stops taking requests.
  initial begin : sink
    int n;
    out_ready = 1'b0;
    forever begin
      if (long_stall_req) begin
        out_ready <= 1'b0;
        for (n = 0; n < LONG_STALL; n++) begin
          @(posedge clk);
        end
        long_stall_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one request and returns at the edge that accepts it. Valid is left high so that
  // the next request can follow without a gap; whoever waits next lowers it first.
  task automatic send_beam(input logic [RNG_W-1:0] fr, input logic [INT_W-1:0] fi,
                           input logic [RNG_W-1:0] rr, input logic [INT_W-1:0] ri,
                           input logic lb, input check_e chk, input logic [NUM_W-1:0] total);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    beam_checks.push_back('{chk, total});
    in_valid           <= 1'b1;
    in_front_range     <= fr;
    in_front_intensity <= fi;
    in_rear_range      <= rr;
    in_rear_intensity  <= ri;
    in_last_beam       <= lb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Configuration writes go out one at a time, with valid dropped in between.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected record has come out, then lets requests that cause no record
  // work their way through the pipeline before the block is treated as idle. The first edge
  // lets the watcher book the records of the request accepted just before.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // One scan of well-formed reflector runs with random content. Each scanner flips between
  // above and below the threshold, with some beams right at it and some pure noise. Dense
  // scans flip often enough to run past the marker cap.
  task automatic send_scan(input int len, input bit dense);
    int               j;
    int               k;
    int               pick;
    int               top;
    int               bot;
    int               v;
    bit               hi [2];
    logic [RNG_W-1:0] rng [2];
    logic [INT_W-1:0] inten [2];
    hi[0] = $urandom_range(0, 1);
    hi[1] = $urandom_range(0, 1);
    for (j = 0; j < len; j++) begin
      if (pause_req && j == len / 2) begin
        // The sender holds back until the block has delivered everything it owes.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_records.size() != 0) @(posedge clk);
        pause_req = 1'b0;
      end
      for (k = 0; k < 2; k++) begin
        if ($urandom_range(0, dense ? 1 : 3) == 0) begin
          hi[k] = !hi[k];
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
          v = $urandom_range(0, 65535);
        end else if (pick == 1) begin
          v = min_level;
        end else if (hi[k] && min_level < 65535) begin
          top = (pick < 8 && min_level < 65471) ? min_level + 64 : 65535;
          v = $urandom_range(min_level + 1, top);
        end else if (!hi[k] && min_level > 0) begin
          bot = (pick < 8 && min_level > 64) ? min_level - 64 : 0;
          v = $urandom_range(bot, min_level - 1);
        end else begin
          v = min_level;
        end
        inten[k] = INT_W'(v);
        pick = $urandom_range(0, 9);
        rng[k] = (pick == 0) ? '0 : (pick == 1) ? '1 : RNG_W'($urandom_range(0, 65535));
      end
      send_beam(rng[0], inten[0], rng[1], inten[1], j == len - 1, BY_MODEL, '0);
    end
  endtask

  initial begin : stimulus
    int                    r;
    int                    ph;
    int                    sent;
    int                    len;
    logic [CFG_DATA_W-1:0] lvl;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_front_range     = '0;
    in_front_intensity = '0;
    in_rear_range      = '0;
    in_rear_intensity  = '0;
    in_last_beam       = 1'b0;
    cfg_valid          = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: extremes of every field, threshold edge cases and every record kind.
    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].op == ROW_CFG) begin
        drain();
        write_reg(dir_rows[r].reg_idx, dir_rows[r].reg_val);
      end else begin
        send_beam(dir_rows[r].f_rng, dir_rows[r].f_int, dir_rows[r].r_rng, dir_rows[r].r_int,
                  dir_rows[r].lb, dir_rows[r].chk, dir_rows[r].total);
      end
    end

    // Random phases, each under a fresh setting. Some phases sit at the threshold extremes and
    // those numbered 3 mod 4 run without idling. The first phase opens with a long dense scan
    // that carries the long output stall and, halfway through, the sender pause.
    sent = 0;
    ph = 0;
    while (sent < RAND_ITEMS) begin
      drain();
      if (ph == 1) begin
        lvl = '0;
      end else if (ph == 3) begin
        lvl = '1;
      end else if ($urandom_range(0, 3) == 0) begin
        lvl = CFG_DATA_W'($urandom_range(1, 40));
      end else begin
        lvl = CFG_DATA_W'($urandom_range(1, 65534));
      end
      write_reg(REG_MIN_INTENSITY, lvl);
      write_reg(REG_MOUNT_OFFSET, (ph == 1) ? CFG_DATA_W'(OFF_MAX) :
                                  CFG_DATA_W'($urandom_range(0, OFF_MAX)));
      gaps_on = (ph % 4 != 3);
      long_stall_req = (ph == 0);
      pause_req = (ph == 0);
      repeat ($urandom_range(2, 5)) begin
        if (sent < RAND_ITEMS) begin
          len = (sent == 0) ? 60 : $urandom_range(2, 70);
          if (sent + len > RAND_ITEMS) begin
            len = (RAND_ITEMS - sent < 2) ? 2 : RAND_ITEMS - sent;
          end
          send_scan(len, (ph == 0) || ($urandom_range(0, 1) == 1));
          sent += len;
        end
      end
      ph++;
    end

    // Closing stretch with both sides running flat out.
    drain();
    write_reg(REG_MIN_INTENSITY, CFG_DATA_W'($urandom_range(1, 65534)));
    write_reg(REG_MOUNT_OFFSET, CFG_DATA_W'($urandom_range(0, OFF_MAX)));
    gaps_on = 1'b0;
    repeat (3) send_scan($urandom_range(10, 40), 1'b1);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("lidar_reflector_marker_detect verification clean");
    end else begin
      $display("lidar_reflector_marker_detect verification failed");
    end
    $finish;
  end

endmodule
